### hw/rtl/sdr_pkg.sv
// Shared types and constants of the servo duty ramp with quadratic easing.
// Used by sdr_div, sdr_seq and servo_duty_ramp_easing; depends on nothing.
package sdr_pkg;

    // Request opcodes
    localparam logic [1:0] OP_TICK = 2'd0;
    localparam logic [1:0] OP_SET  = 2'd1;
    localparam logic [1:0] OP_STOP = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_MIN_DUTY = 2'd0;
    localparam logic [1:0] CFG_MAX_DUTY = 2'd1;
    localparam logic [1:0] CFG_DEF_RAMP = 2'd2;

    localparam logic [13:0] DUTY_FULL   = 14'd10000;
    localparam logic [16:0] Q16_ONE     = 17'd65536;
    localparam logic [15:0] Q16_HALF    = 16'd32768;
    localparam logic [33:0] ROUND_HALF  = 34'd32768;
    localparam logic [4:0]  TIME_STEPS  = 5'd16;
    localparam logic [4:0]  POS_STEPS   = 5'd14;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [16:0] position;
        logic [15:0] ramp_ms;
        logic        use_default;
    } t_item;

    typedef struct packed {
        logic [13:0] min_duty;
        logic [13:0] max_duty;
        logic [15:0] default_ramp_ms;
    } t_cfg;

    typedef struct packed {
        logic        ramp_done;
        logic [15:0] remaining_ms;
        logic [13:0] target_position;
        logic [13:0] current_position;
        logic        ramping;
        logic [13:0] duty;
    } t_result;

    // Divider start request and number of quotient bits to produce
    typedef struct packed {
        logic       start;
        logic [4:0] steps;
    } t_div_cmd;

endpackage

### hw/rtl/sdr_div.sv
// Restoring divider, one quotient bit per cycle, shared by the ramp sequencer.
// Depends on sdr_pkg.
module sdr_div #(
    parameter int DW = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  sdr_pkg::t_div_cmd i_cmd,
    input  logic [DW-1:0]   i_rem,
    input  logic [15:0]     i_lo,
    input  logic [DW-1:0]   i_den,
    output logic            o_done,
    output logic [15:0]     o_quot
);
    import sdr_pkg::*;

    logic [DW-1:0] r_rem, r_den;
    logic [15:0]   r_lo, r_q;
    logic [4:0]    r_cnt;
    logic          r_busy, r_fin;
    logic [DW:0]   trial, diff;
    logic          ge;

    // Bring down the next numerator bit and try the subtract
    always_comb begin
        trial = {r_rem, r_lo[15]};
        diff  = trial - {1'b0, r_den};
        ge    = (trial >= {1'b0, r_den});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_fin <= 1'b0;
            if (i_cmd.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_cmd.steps;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 5'd1;
                if (r_cnt == 5'd1) begin
                    r_busy <= 1'b0;
                    r_fin  <= 1'b1;
                end
            end
        end
    end

    // Datapath: load, then shift one bit per cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_rem <= i_rem;
            r_lo  <= i_lo;
            r_den <= i_den;
            r_q   <= '0;
        end else if (r_busy) begin
            r_rem <= ge ? diff[DW-1:0] : trial[DW-1:0];
            r_lo  <= {r_lo[14:0], 1'b0};
            r_q   <= {r_q[14:0], ge};
        end
    end

    assign o_done = r_fin;
    assign o_quot = r_q;

endmodule

### hw/rtl/sdr_seq.sv
// Ramp sequencer: ramp state, shared multiplier and control of the shared divider.
// Depends on sdr_pkg and sdr_div.
module sdr_seq #(
    parameter int TIME_BITS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  sdr_pkg::t_item    i_item,
    input  sdr_pkg::t_cfg     i_cfg,
    output logic              o_idle,
    output logic              o_done,
    output sdr_pkg::t_result  o_result
);
    import sdr_pkg::*;

    localparam int DW = (TIME_BITS > 14) ? TIME_BITS : 14;
    localparam int LW = (TIME_BITS > 16) ? TIME_BITS : 16;
    localparam logic [TIME_BITS-1:0] TMAX = {TIME_BITS{1'b1}};
    localparam logic [LW-1:0] TMAX_W = LW'(TMAX);

    typedef enum logic [13:0] {
        S_IDLE  = 14'b00000000000001,
        S_TICK  = 14'b00000000000010,
        S_TDIV  = 14'b00000000000100,
        S_EMUL  = 14'b00000000001000,
        S_EASE  = 14'b00000000010000,
        S_LMUL  = 14'b00000000100000,
        S_LERP  = 14'b00000001000000,
        S_SETUP = 14'b00000010000000,
        S_SMUL  = 14'b00000100000000,
        S_SET   = 14'b00001000000000,
        S_PCHK  = 14'b00010000000000,
        S_PMUL  = 14'b00100000000000,
        S_PDIV  = 14'b01000000000000,
        S_PWAIT = 14'b10000000000000
    } t_state;

    t_state r_state;
    t_item  r_item;
    logic [13:0] r_cur, r_start, r_tgt, r_pos_cur, r_pos_tgt;
    logic [TIME_BITS-1:0] r_el, r_len;
    logic r_act, r_done_flag, r_psel, r_fin;
    logic [16:0] r_ma, r_mb;
    logic [33:0] r_prod;
    logic [15:0] r_t;

    logic [TIME_BITS-1:0] el_inc, len_sat;
    logic [LW-1:0] len_ext, rem_full;
    logic [15:0] len_sel;
    logic [16:0] pos_c, ease_e;
    logic [33:0] rnd;
    logic [13:0] d_rnd, set_duty, pd, span;
    logic [27:0] num;
    logic [16:0] sq_op;
    t_div_cmd div_cmd;
    logic [DW-1:0] div_rem, div_den;
    logic [15:0] div_lo, div_q;
    logic div_done;

    sdr_div #(.DW(DW)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (div_cmd),
        .i_rem   (div_rem),
        .i_lo    (div_lo),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (div_q)
    );

    // Shared multiplier, one product per cycle
    always_ff @(posedge i_clk) begin
        r_prod <= 34'(r_ma) * 34'(r_mb);
    end

    // Arithmetic around the shared units
    always_comb begin
        el_inc   = (r_el != TMAX) ? r_el + 1'b1 : r_el;
        len_sel  = r_item.use_default ? i_cfg.default_ramp_ms : r_item.ramp_ms;
        len_ext  = LW'(len_sel);
        len_sat  = (len_ext > TMAX_W) ? TMAX : len_ext[TIME_BITS-1:0];
        rem_full = LW'(r_len) - LW'(r_el);
        pos_c    = (r_item.position > Q16_ONE) ? Q16_ONE : r_item.position;
        rnd      = r_prod + ROUND_HALF;
        d_rnd    = rnd[29:16];
        ease_e   = (r_t < Q16_HALF) ? r_prod[31:15] : Q16_ONE - r_prod[31:15];
        sq_op    = (r_t < Q16_HALF) ? 17'(r_t) : Q16_ONE - 17'(r_t);
        set_duty = (i_cfg.max_duty >= i_cfg.min_duty) ? i_cfg.min_duty + d_rnd
                                                      : i_cfg.min_duty - d_rnd;
        if (set_duty > DUTY_FULL) begin
            set_duty = DUTY_FULL;
        end
        span = i_cfg.max_duty - i_cfg.min_duty;
        pd   = r_psel ? r_tgt : r_cur;
        num  = r_prod[27:0] + 28'(span[13:1]);
    end

    // Divider requests: ramp progress or duty-to-position
    always_comb begin
        div_cmd = '0;
        div_rem = DW'(el_inc);
        div_lo  = '0;
        div_den = DW'(r_len);
        if (r_state == S_TICK && r_act && el_inc < r_len) begin
            div_cmd.start = 1'b1;
            div_cmd.steps = TIME_STEPS;
        end else if (r_state == S_PDIV) begin
            div_cmd.start = 1'b1;
            div_cmd.steps = POS_STEPS;
            div_rem       = DW'(num[27:14]);
            div_lo        = {num[13:0], 2'b00};
            div_den       = DW'(span);
        end
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cur       <= '0;
            r_start     <= '0;
            r_tgt       <= '0;
            r_el        <= '0;
            r_len       <= '0;
            r_act       <= 1'b0;
            r_done_flag <= 1'b0;
            r_psel      <= 1'b0;
            r_fin       <= 1'b0;
        end else begin
            r_fin <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_item      <= i_item;
                        r_done_flag <= 1'b0;
                        r_psel      <= 1'b0;
                        priority case (i_item.opcode)
                            OP_TICK: r_state <= S_TICK;
                            OP_SET:  r_state <= S_SETUP;
                            OP_STOP: begin
                                r_cur   <= '0;
                                r_act   <= 1'b0;
                                r_state <= S_PCHK;
                            end
                            default: r_state <= S_PCHK;
                        endcase
                    end
                end
                S_TICK: begin
                    if (!r_act) begin
                        r_state <= S_PCHK;
                    end else if (el_inc >= r_len) begin
                        r_el        <= el_inc;
                        r_cur       <= r_tgt;
                        r_act       <= 1'b0;
                        r_done_flag <= 1'b1;
                        r_state     <= S_PCHK;
                    end else begin
                        r_el    <= el_inc;
                        r_state <= S_TDIV;
                    end
                end
                S_TDIV: begin
                    if (div_done) begin
                        r_t     <= div_q;
                        r_state <= S_EMUL;
                    end
                end
                S_EMUL: begin
                    // operands for the square go in this cycle
                    r_ma    <= sq_op;
                    r_mb    <= sq_op;
                    r_state <= S_EASE;
                end
                S_EASE: begin
                    r_state <= S_LMUL;
                end
                S_LMUL: begin
                    r_ma    <= (r_tgt >= r_start) ? 17'(r_tgt - r_start)
                                                  : 17'(r_start - r_tgt);
                    r_mb    <= ease_e;
                    r_state <= S_LERP;
                end
                S_LERP: begin
                    r_state <= S_SMUL;
                    r_psel  <= 1'b1;
                end
                S_SETUP: begin
                    r_ma    <= (i_cfg.max_duty >= i_cfg.min_duty)
                               ? 17'(i_cfg.max_duty - i_cfg.min_duty)
                               : 17'(i_cfg.min_duty - i_cfg.max_duty);
                    r_mb    <= pos_c;
                    r_state <= S_SMUL;
                end
                S_SMUL: begin
                    r_state <= S_SET;
                end
                S_SET: begin
                    if (r_psel) begin
                        // eased lerp result from the tick path
                        r_cur <= (r_tgt >= r_start) ? r_start + d_rnd : r_start - d_rnd;
                        r_psel <= 1'b0;
                    end else if (len_sat == '0) begin
                        r_cur <= set_duty;
                        r_act <= 1'b0;
                    end else begin
                        r_start <= r_cur;
                        r_tgt   <= set_duty;
                        r_el    <= '0;
                        r_len   <= len_sat;
                        r_act   <= 1'b1;
                    end
                    r_state <= S_PCHK;
                end
                S_PCHK: begin
                    if (i_cfg.max_duty <= i_cfg.min_duty || pd <= i_cfg.min_duty ||
                        pd >= i_cfg.max_duty) begin
                        if (r_psel) begin
                            r_pos_tgt <= (i_cfg.max_duty > i_cfg.min_duty &&
                                          pd >= i_cfg.max_duty) ? DUTY_FULL : '0;
                            r_fin     <= 1'b1;
                            r_state   <= S_IDLE;
                        end else begin
                            r_pos_cur <= (i_cfg.max_duty > i_cfg.min_duty &&
                                          pd >= i_cfg.max_duty) ? DUTY_FULL : '0;
                            r_psel    <= 1'b1;
                        end
                    end else begin
                        r_ma    <= 17'(pd - i_cfg.min_duty);
                        r_mb    <= 17'(DUTY_FULL);
                        r_state <= S_PMUL;
                    end
                end
                S_PMUL: begin
                    r_state <= S_PDIV;
                end
                S_PDIV: begin
                    r_state <= S_PWAIT;
                end
                S_PWAIT: begin
                    if (div_done) begin
                        if (r_psel) begin
                            r_pos_tgt <= div_q[13:0];
                            r_fin     <= 1'b1;
                            r_state   <= S_IDLE;
                        end else begin
                            r_pos_cur <= div_q[13:0];
                            r_psel    <= 1'b1;
                            r_state   <= S_PCHK;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Report the state after the request
    always_comb begin
        o_result.duty             = r_cur;
        o_result.ramping          = r_act;
        o_result.current_position = r_pos_cur;
        o_result.target_position  = r_act ? r_pos_tgt : '0;
        o_result.remaining_ms     = r_act ? rem_full[15:0] : '0;
        o_result.ramp_done        = r_done_flag;
    end

    assign o_idle = (r_state == S_IDLE) && !r_fin;
    assign o_done = r_fin;

endmodule

### hw/rtl/servo_duty_ramp_easing.sv
// Servo duty ramp top level: stream ports, configuration registers, result register.
// Depends on sdr_pkg and sdr_seq.

// Takes one request at a time (tick, set position, stop) and returns one result
// per request. A tick while ramping that does not end the ramp waits on the
// shared divider for the ramp progress and uses the shared multiplier twice for
// the easing. A set position uses the multiplier once. Every request then
// converts the current and target duty back to a position. A duty strictly
// inside the configured range uses the shared divider (14 quotient bits); one at
// or beyond a range end skips the divider. The input is not ready until the
// previous result has been taken, so a new request is not accepted before the
// last one is through. Configuration writes are always accepted and belong in
// idle periods.
module servo_duty_ramp_easing #(
    parameter int TIME_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // [16:0] position, [32:17] ramp_ms, [33] use_default, zero padded
    input  logic [39:0] i_s_tdata,
    // [1:0] opcode
    input  logic [1:0]  i_s_tuser,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // [13:0] duty, [14] ramping, [28:15] current_position,
    // [42:29] target_position, [58:43] remaining_ms, [59] ramp_done
    output logic [63:0] o_m_tdata,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    import sdr_pkg::*;

    t_cfg    r_cfg;
    t_item   item;
    t_result seq_res, r_res;
    logic    r_m_valid, seq_idle, seq_done, s_take;

    // Unpack the request
    always_comb begin
        item.opcode      = i_s_tuser;
        item.position    = i_s_tdata[16:0];
        item.ramp_ms     = i_s_tdata[32:17];
        item.use_default = i_s_tdata[33];
    end

    assign o_s_tready  = seq_idle && !r_m_valid;
    assign s_take      = i_s_tvalid && o_s_tready;
    assign o_cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_duty        <= 14'd500;
            r_cfg.max_duty        <= 14'd1000;
            r_cfg.default_ramp_ms <= 16'd1000;
        end else if (i_cfg_valid) begin
            priority case (i_cfg_index)
                CFG_MIN_DUTY: r_cfg.min_duty        <= i_cfg_data[13:0];
                CFG_MAX_DUTY: r_cfg.max_duty        <= i_cfg_data[13:0];
                CFG_DEF_RAMP: r_cfg.default_ramp_ms <= i_cfg_data;
                default:      r_cfg <= r_cfg;
            endcase
        end
    end

    sdr_seq #(.TIME_BITS(TIME_BITS)) u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (s_take),
        .i_item   (item),
        .i_cfg    (r_cfg),
        .o_idle   (seq_idle),
        .o_done   (seq_done),
        .o_result (seq_res)
    );

    // Hold the result until the downstream side takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (seq_done) begin
            r_m_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (seq_done) begin
            r_res <= seq_res;
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = {4'b0000, r_res.ramp_done, r_res.remaining_ms,
                         r_res.target_position, r_res.current_position,
                         r_res.ramping, r_res.duty};

endmodule
